>>> rtl/core/pis_pkg.sv
package pis_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam int FIELD_W    = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [31:0] DEFAULT_PERIOD = 32'd60;
  localparam logic [7:0]  BACKOFF_LIMIT  = 8'd10;
  localparam logic [11:0] BACKOFF_UNIT   = 12'd5;
  localparam logic [11:0] BACKOFF_MAX    = 12'd2560;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIODIC_ENABLE = 2'd0,
    REG_PERIOD_SECONDS  = 2'd1,
    REG_BASE_TIME       = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FIRE,
    ST_DIV,
    ST_GRID,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic fire;
    logic div_start;
    logic div_step;
    logic grid;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic due_zero;
    logic div_last;
  } status_t;

endpackage

>>> rtl/core/pis_datapath.sv
module pis_datapath
  import pis_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [FIELD_W-1:0]    in_now,
  input  logic [7:0]            in_failures,
  input  logic [7:0]            in_jitter,
  input  logic                  in_changed,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  out_inform,
  output logic [FIELD_W-1:0]    out_next_due
);

  localparam int CNT_W = $clog2(TIME_BITS + 1);

  typedef logic [TIME_BITS-1:0] time_t;

  logic                  enable_r;
  logic [CFG_DATA_W-1:0] period_r;
  logic [CFG_DATA_W-1:0] base_r;

  time_t       now_r;
  logic [7:0]  fails_r;
  logic [7:0]  jit_r;
  logic        changed_r;

  time_t       anchor_r, anchor_nxt;
  time_t       due_r, due_nxt;
  logic        loaded_r;
  logic [12:0] wt_r;
  logic        fire_r;

  time_t             dvd_r;
  logic [31:0]       rem_r;
  logic [CNT_W-1:0]  cnt_r;

  logic              out_inform_r;
  logic [FIELD_W-1:0] out_due_r;

  logic [31:0] ival;
  time_t       ival_t;

  // Evaluation stage signals.
  logic        reload;
  time_t       anchor0, due0, anchor_e, due_e;
  logic [3:0]  shamt;
  logic [11:0] w;
  logic [19:0] prod;
  logic [12:0] wt;

  // Fire stage signals.
  logic        hit;
  time_t       due_f;

  // Divider and grid signals.
  logic [32:0] sh;
  logic [32:0] dsr;
  time_t       r_t;
  time_t       due_g;

  assign ival   = (period_r == '0) ? DEFAULT_PERIOD : period_r;
  assign ival_t = TIME_BITS'(ival);

  always_comb begin
    reload  = changed_r || !loaded_r;
    anchor0 = reload ? TIME_BITS'(base_r) : anchor_r;
    due0    = reload ? '0 : due_r;
    if (anchor0 == '0) begin
      anchor_e = now_r;
      due_e    = now_r + ival_t;
    end else if (anchor0 > now_r) begin
      anchor_e = anchor0;
      due_e    = anchor0;
    end else begin
      anchor_e = anchor0;
      due_e    = due0;
    end

    shamt = 4'(fails_r - 8'd1);
    if (fails_r < BACKOFF_LIMIT) begin
      w = BACKOFF_UNIT << shamt;
    end else begin
      w = BACKOFF_MAX;
    end
    prod = 20'(w) * 20'(jit_r);
    wt   = 13'(w) + 13'(prod[19:8]);
  end

  always_comb begin
    hit = (due_r != '0) && (due_r <= now_r);
    if (!hit) begin
      due_f = due_r;
    end else if (fails_r != 8'd0) begin
      due_f = now_r + TIME_BITS'(wt_r);
    end else if (due_r == now_r) begin
      due_f = due_r + ival_t;
    end else begin
      due_f = '0;
    end
  end

  // Restoring divider; only the remainder is kept.
  assign sh  = {rem_r, dvd_r[TIME_BITS-1]};
  assign dsr = {1'b0, ival};

  // Since diff = q * interval + r, the grid point anchor + (q + 1) * interval
  // equals now - r + interval; due_g adds one more interval on an exact hit.
  assign r_t   = TIME_BITS'(rem_r);
  assign due_g = now_r - r_t + ival_t + ((rem_r == '0) ? ival_t : '0);

  assign status.due_zero = (due_f == '0);
  assign status.div_last = (cnt_r == CNT_W'(TIME_BITS - 1));

  always_comb begin
    anchor_nxt = anchor_r;
    due_nxt    = due_r;
    if (cmd.eval) begin
      anchor_nxt = anchor_e;
      due_nxt    = due_e;
    end else if (cmd.fire) begin
      due_nxt = due_f;
    end else if (cmd.grid) begin
      due_nxt = due_g;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      period_r <= '0;
      base_r   <= '0;
      anchor_r <= '0;
      due_r    <= '0;
      loaded_r <= 1'b0;
    end else begin
      anchor_r <= anchor_nxt;
      due_r    <= due_nxt;
      if (cmd.eval) begin
        loaded_r <= 1'b1;
      end
      if (cfg_wen) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PERIODIC_ENABLE: enable_r <= cfg_wdata[0];
          REG_PERIOD_SECONDS:  period_r <= cfg_wdata;
          REG_BASE_TIME:       base_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r     <= TIME_BITS'(in_now);
      fails_r   <= in_failures;
      jit_r     <= in_jitter;
      changed_r <= in_changed;
    end
    if (cmd.eval) begin
      wt_r <= wt;
    end
    if (cmd.fire) begin
      fire_r <= hit & enable_r;
    end
    if (cmd.div_start) begin
      dvd_r <= now_r - anchor_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (sh >= dsr) begin
        rem_r <= 32'(sh - dsr);
      end else begin
        rem_r <= sh[31:0];
      end
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_inform_r <= fire_r;
      out_due_r    <= FIELD_W'(due_r);
    end
  end

  assign out_inform   = out_inform_r;
  assign out_next_due = out_due_r;

endmodule

>>> rtl/core/pis_ctrl.sv
module pis_ctrl
  import pis_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_FIRE;
      end
      ST_FIRE: begin
        cmd.fire = 1'b1;
        if (status.due_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_GRID;
        end
      end
      ST_GRID: begin
        cmd.grid  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Wait here only while the output register still holds an untaken item.
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> rtl/core/periodic_inform_scheduler.sv
// From input accept to out_tvalid, an item passes through the EVAL, FIRE and DONE states
// when no grid realignment is needed, and EVAL, FIRE, DIV, GRID and DONE when the due
// time is realigned to the interval grid; a new item is taken only back in IDLE. The
// realignment runs a one-bit-per-cycle remainder divider over the elapsed time.
// Reset (rst_n low, synchronous): config registers, due time and anchor clear to
// zero, the anchor reload flag clears, and no result is pending.
module periodic_inform_scheduler
  import pis_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // now_seconds[31:0], failures[39:32], jitter[47:40]
  input  logic [0:0]            in_tuser,   // settings_changed[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // next_due_time[31:0]
  output logic [0:0]            out_tuser   // inform_due[0]
);

  cmd_t    cmd;
  status_t status;

  pis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  pis_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_now       (in_tdata[31:0]),
    .in_failures  (in_tdata[39:32]),
    .in_jitter    (in_tdata[47:40]),
    .in_changed   (in_tuser[0]),
    .cmd          (cmd),
    .status       (status),
    .out_inform   (out_tuser[0]),
    .out_next_due (out_tdata)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is still in work");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("result load did not raise out_tvalid");

  a_div_to_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && status.div_last) |=> (cmd.grid && !cmd.div_step))
    else $error("divider end not followed by grid step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

endmodule
